// ===== design/fbd_pkg.sv =====
package fbd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned POS_W    = 11;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned PACKET_W = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;

   localparam int unsigned MAX_FRAME_BYTES = 1024;
   localparam int unsigned RING_SLOTS      = 16;

   localparam logic [KIND_W-1:0] RESULT_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] RESULT_PAYLOAD  = 2'd1;
   localparam logic [KIND_W-1:0] RESULT_CTL_END  = 2'd2;
   localparam logic [KIND_W-1:0] RESULT_PIPE_END = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNSTUFF_MASK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIPE_IDENT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PACKETS_PER  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_RING = 3'd6;

   localparam logic [BYTE_W-1:0]   RST_START_CODE   = 8'd126;
   localparam logic [BYTE_W-1:0]   RST_END_CODE     = 8'd125;
   localparam logic [BYTE_W-1:0]   RST_ESCAPE_CODE  = 8'd124;
   localparam logic [BYTE_W-1:0]   RST_UNSTUFF_MASK = 8'd32;
   localparam logic [BYTE_W-1:0]   RST_PIPE_IDENT   = 8'd0;
   localparam logic [PACKET_W-1:0] RST_PACKETS_PER  = 8'd4;

   typedef enum logic [3:0] {
      FRAME_NONE  = 4'b0001,
      FRAME_AWAIT = 4'b0010,
      FRAME_CTL   = 4'b0100,
      FRAME_PIPE  = 4'b1000
   } frame_state_type;

endpackage

// ===== design/framed_byte_deframer_core.sv =====
// Byte-stuffed frame receiver. One received byte is taken per clock unless
// back-pressure on rsp_ready stalls the result register, and each byte gives
// exactly one result transfer. From req transfer to rsp valid a byte passes
// the input register and then the decode into the result register. A new byte is
// taken while a finished result still waits, as long as the input register is
// free. Configuration writes take effect on the next clock and must only be
// made while no byte is in flight; a write of one to restart_ring clears the
// slot ring, packet counter and block start slot.
module framed_byte_deframer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fbd_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fbd_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [fbd_pkg::BYTE_W-1:0]          rsp_payload_byte,
   output logic [fbd_pkg::POS_W-1:0]           rsp_byte_position,
   output logic                                rsp_payload_is_pipe,
   output logic [fbd_pkg::SLOT_W-1:0]          rsp_pipe_slot,
   output logic                                rsp_block_done,
   output logic [fbd_pkg::SLOT_W-1:0]          rsp_block_first_slot,
   output logic                                rsp_overflow,
   input  logic                                csr_write_en,
   input  logic [fbd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fbd_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int unsigned CNT_W  = $clog2(fbd_pkg::MAX_FRAME_BYTES + 1);
   localparam int unsigned RING_W = (fbd_pkg::RING_SLOTS > 1) ?
                                    $clog2(fbd_pkg::RING_SLOTS) : 1;
   localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(fbd_pkg::MAX_FRAME_BYTES);
   localparam logic [RING_W-1:0] LAST_SLOT = RING_W'(fbd_pkg::RING_SLOTS - 1);

   // configuration
   logic [fbd_pkg::BYTE_W-1:0]   start_code_ff;
   logic [fbd_pkg::BYTE_W-1:0]   end_code_ff;
   logic [fbd_pkg::BYTE_W-1:0]   escape_code_ff;
   logic [fbd_pkg::BYTE_W-1:0]   unstuff_mask_ff;
   logic [fbd_pkg::BYTE_W-1:0]   pipe_ident_ff;
   logic [fbd_pkg::PACKET_W-1:0] packets_per_ff;
   logic                         restart_ring;

   // input stage
   logic                         in_valid_ff;
   logic [fbd_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                         advance;

   // frame state
   fbd_pkg::frame_state_type     frame_ff, frame_in;
   logic                         escape_ff, escape_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [RING_W-1:0]            head_ff, head_in;
   logic [fbd_pkg::PACKET_W-1:0] packets_ff, packets_in;
   logic [RING_W-1:0]            block_start_ff, block_start_in;

   // result stage
   logic                         out_valid_ff;
   logic [fbd_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [fbd_pkg::BYTE_W-1:0]   pay_ff, pay_in;
   logic [fbd_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                         is_pipe_ff, is_pipe_in;
   logic [fbd_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                         bdone_ff, bdone_in;
   logic [fbd_pkg::SLOT_W-1:0]   bfirst_ff, bfirst_in;
   logic                         ovf_ff, ovf_in;

   logic                         in_frame;
   logic                         store;
   logic [fbd_pkg::BYTE_W-1:0]   store_val;
   logic [RING_W-1:0]            head_step;
   logic [fbd_pkg::PACKET_W-1:0] packets_step;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_frame  = (frame_ff != fbd_pkg::FRAME_NONE);
   assign head_step    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign packets_step = packets_ff + 1'b1;
   assign restart_ring = csr_write_en && (csr_index == fbd_pkg::CSR_RESTART_RING)
                         && csr_write_data[0];

   always_comb begin
      frame_in       = frame_ff;
      escape_in      = escape_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      packets_in     = packets_ff;
      block_start_in = block_start_ff;
      kind_in        = fbd_pkg::RESULT_NONE;
      pay_in         = '0;
      pos_in         = '0;
      is_pipe_in     = 1'b0;
      slot_in        = '0;
      bdone_in       = 1'b0;
      bfirst_in      = '0;
      ovf_in         = 1'b0;
      store          = 1'b0;
      store_val      = '0;

      if (in_byte_ff == end_code_ff && in_frame) begin
         case (frame_ff)
            fbd_pkg::FRAME_CTL: begin
               kind_in = fbd_pkg::RESULT_CTL_END;
               pos_in  = fbd_pkg::POS_W'(count_ff);
            end
            fbd_pkg::FRAME_PIPE: begin
               kind_in    = fbd_pkg::RESULT_PIPE_END;
               pos_in     = fbd_pkg::POS_W'(count_ff);
               is_pipe_in = 1'b1;
               slot_in    = fbd_pkg::SLOT_W'(head_ff);
               head_in    = head_step;
               packets_in = packets_step;
               if (packets_step == packets_per_ff) begin
                  packets_in     = '0;
                  bdone_in       = 1'b1;
                  bfirst_in      = fbd_pkg::SLOT_W'(block_start_ff);
                  block_start_in = head_step;
               end
            end
            default: begin
            end
         endcase
         frame_in  = fbd_pkg::FRAME_NONE;
         escape_in = 1'b0;
      end else if (in_byte_ff == start_code_ff) begin
         frame_in  = fbd_pkg::FRAME_AWAIT;
         escape_in = 1'b0;
         count_in  = '0;
      end else if (!in_frame) begin
         // byte outside a frame is dropped
      end else if (frame_ff == fbd_pkg::FRAME_AWAIT) begin
         frame_in  = (in_byte_ff == pipe_ident_ff) ? fbd_pkg::FRAME_PIPE
                                                   : fbd_pkg::FRAME_CTL;
         store     = 1'b1;
         store_val = in_byte_ff;
      end else if (in_byte_ff == escape_code_ff) begin
         escape_in = 1'b1;
      end else if (escape_ff) begin
         escape_in = 1'b0;
         store     = 1'b1;
         store_val = in_byte_ff ^ unstuff_mask_ff;
      end else begin
         store     = 1'b1;
         store_val = in_byte_ff;
      end

      if (store) begin
         is_pipe_in = (frame_in == fbd_pkg::FRAME_PIPE);
         slot_in    = is_pipe_in ? fbd_pkg::SLOT_W'(head_ff) : '0;
         if (count_ff >= MAX_COUNT) begin
            ovf_in = 1'b1;
         end else begin
            kind_in  = fbd_pkg::RESULT_PAYLOAD;
            pay_in   = store_val;
            pos_in   = fbd_pkg::POS_W'(count_ff);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff   <= fbd_pkg::RST_START_CODE;
         end_code_ff     <= fbd_pkg::RST_END_CODE;
         escape_code_ff  <= fbd_pkg::RST_ESCAPE_CODE;
         unstuff_mask_ff <= fbd_pkg::RST_UNSTUFF_MASK;
         pipe_ident_ff   <= fbd_pkg::RST_PIPE_IDENT;
         packets_per_ff  <= fbd_pkg::RST_PACKETS_PER;
      end else if (csr_write_en) begin
         case (csr_index)
            fbd_pkg::CSR_START_CODE:   start_code_ff   <= csr_write_data;
            fbd_pkg::CSR_END_CODE:     end_code_ff     <= csr_write_data;
            fbd_pkg::CSR_ESCAPE_CODE:  escape_code_ff  <= csr_write_data;
            fbd_pkg::CSR_UNSTUFF_MASK: unstuff_mask_ff <= csr_write_data;
            fbd_pkg::CSR_PIPE_IDENT:   pipe_ident_ff   <= csr_write_data;
            fbd_pkg::CSR_PACKETS_PER:  packets_per_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff       <= fbd_pkg::FRAME_NONE;
         escape_ff      <= 1'b0;
         count_ff       <= '0;
         head_ff        <= '0;
         packets_ff     <= '0;
         block_start_ff <= '0;
      end else begin
         if (advance) begin
            frame_ff       <= frame_in;
            escape_ff      <= escape_in;
            count_ff       <= count_in;
            head_ff        <= head_in;
            packets_ff     <= packets_in;
            block_start_ff <= block_start_in;
         end
         if (restart_ring) begin
            head_ff        <= '0;
            packets_ff     <= '0;
            block_start_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         kind_ff    <= kind_in;
         pay_ff     <= pay_in;
         pos_ff     <= pos_in;
         is_pipe_ff <= is_pipe_in;
         slot_ff    <= slot_in;
         bdone_ff   <= bdone_in;
         bfirst_ff  <= bfirst_in;
         ovf_ff     <= ovf_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_payload_byte     = pay_ff;
   assign rsp_byte_position    = pos_ff;
   assign rsp_payload_is_pipe  = is_pipe_ff;
   assign rsp_pipe_slot        = slot_ff;
   assign rsp_block_done       = bdone_ff;
   assign rsp_block_first_slot = bfirst_ff;
   assign rsp_overflow         = ovf_ff;

endmodule

// ===== design/fbd_checker.sv =====
module fbd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [fbd_pkg::KIND_W-1:0]       rsp_result_kind,
   input logic [fbd_pkg::BYTE_W-1:0]       rsp_payload_byte,
   input logic [fbd_pkg::POS_W-1:0]        rsp_byte_position,
   input logic                             rsp_payload_is_pipe,
   input logic [fbd_pkg::SLOT_W-1:0]       rsp_pipe_slot,
   input logic                             rsp_block_done,
   input logic [fbd_pkg::SLOT_W-1:0]       rsp_block_first_slot,
   input logic                             rsp_overflow
);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_byte_position))
      else $error("stalled result changed");

   a_block_on_pipe_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_done |-> rsp_result_kind == fbd_pkg::RESULT_PIPE_END)
      else $error("block done without pipe frame end");

   a_overflow_drops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_result_kind == fbd_pkg::RESULT_NONE
         && rsp_byte_position == '0)
      else $error("overflow byte not dropped");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != fbd_pkg::RESULT_PAYLOAD |-> rsp_payload_byte == '0)
      else $error("payload byte set outside payload transfer");

   a_slot_pipe_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_is_pipe |-> rsp_pipe_slot == '0
         && rsp_block_first_slot == '0 && !rsp_block_done)
      else $error("slot reported for non-pipe frame");

endmodule

bind framed_byte_deframer_core fbd_checker u_fbd_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_result_kind      (rsp_result_kind),
   .rsp_payload_byte     (rsp_payload_byte),
   .rsp_byte_position    (rsp_byte_position),
   .rsp_payload_is_pipe  (rsp_payload_is_pipe),
   .rsp_pipe_slot        (rsp_pipe_slot),
   .rsp_block_done       (rsp_block_done),
   .rsp_block_first_slot (rsp_block_first_slot),
   .rsp_overflow         (rsp_overflow)
);
